>>> hw/rtl/wscd_pkg.sv
// ----------------------------------------------------------------------------
// wscd_pkg: shared types and constants of the state cycle detector
// Control state encodings, result status codes, config register indexes
// and the small helpers used across the detector.
// ----------------------------------------------------------------------------
package wscd_pkg;

	// config register indexes
	localparam logic CFG_WINDOW_SIZE = 1'b0;
	localparam logic CFG_STEP_LIMIT  = 1'b1;

	// reset values of the config registers
	localparam logic [5:0]  WINDOW_SIZE_RST = 6'd32;
	localparam logic [23:0] STEP_LIMIT_RST  = 24'hFFFFFF;

	// step counter saturation value
	localparam logic [23:0] STEP_MAX = 24'hFFFFFF;

	// result status codes
	typedef enum logic [1:0] {
		STAT_SEARCH = 2'd0,
		STAT_FOUND  = 2'd1,
		STAT_LIMIT  = 2'd2
	} status_t;

	// control sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SCAN,
		ST_COUNT,
		ST_DONE
	} fsm_t;

	// operation applied to every cell of the window chain
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_DRAIN
	} cell_op_t;

	// ones in one byte
	function automatic logic [3:0] pop8(input logic [7:0] v);
		logic [3:0] n;
		n = '0;
		for (int k = 0; k < 8; k++) begin
			n = n + {3'b000, v[k]};
		end
		return n;
	endfunction

endpackage

>>> hw/rtl/wscd_cell.sv
// ----------------------------------------------------------------------------
// wscd_cell: one entry of the state window chain
// Holds one stored state, shifts it to the older neighbor on a push or
// to the newer neighbor on a drain, and flags equality with the probe.
// ----------------------------------------------------------------------------
module wscd_cell #(
	parameter int W = 64
) (
	input  logic               clk,
	input  wscd_pkg::cell_op_t op,
	input  logic [W-1:0]       newer_data,
	input  logic [W-1:0]       older_data,
	input  logic [W-1:0]       probe,
	output logic [W-1:0]       entry,
	output logic               hit
);

	logic [W-1:0] entry_q;

	// entry register, shifted by the chain operation
	always_ff @(posedge clk) begin
		case (op)
			wscd_pkg::CELL_PUSH:  entry_q <= newer_data;
			wscd_pkg::CELL_DRAIN: entry_q <= older_data;
			default:              entry_q <= entry_q;
		endcase
	end

	// equality with the incoming state
	assign hit   = (entry_q == probe);
	assign entry = entry_q;

endmodule

>>> hw/rtl/windowed_state_cycle_detector_top.sv
// ----------------------------------------------------------------------------
// windowed_state_cycle_detector_top: sliding window cycle detector
// An accepted beat is captured and evaluated against the window; when a cycle
// of length d is found, the window chain drains d entries before the result beat.
// The input stalls until the result is loaded; the sequencer holds one item at a
// time and the output register frees the input side early.
// Reset: control and config registers cleared (window_size 32, step_limit
// max); window entries are undefined and tracked by the fill count.
// ----------------------------------------------------------------------------
module windowed_state_cycle_detector_top #(
	parameter int NODES  = 64,
	parameter int WINDOW = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        cfg_en,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] state_bits,
	input  logic        restart,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [5:0]  cycle_length,
	output logic [63:0] cycle_name,
	output logic [63:0] fixed_mask,
	output logic [6:0]  floating_count
);

	localparam int CW = $clog2(WINDOW + 1);
	localparam int EW = (CW > 6) ? CW : 6;
	localparam int IW = $clog2(WINDOW);
	localparam int NB = (NODES + 7) / 8;
	localparam logic [NODES-1:0] NODE_MASK = '1;

	wscd_pkg::fsm_t     state_q, state_d;
	wscd_pkg::cell_op_t cell_op;
	wscd_pkg::status_t  status_q, status_eff;

	logic [5:0]       window_size_q;
	logic [23:0]      step_limit_q;
	logic [CW-1:0]    fill_q, fill_eff, fill_inc;
	logic [23:0]      step_q, step_eff, step_inc;
	logic [NODES-1:0] s_q;
	logic             rst_q;
	logic [5:0]       held_len_q, cnt_q, d_val;
	logic [NODES-1:0] held_name_q, held_mask_q, acc_name_q, acc_mask_q;
	logic [NODES-1:0] scan_name, scan_mask;
	logic [3:0]       byte_cnt_q [NB];
	logic [NB*8-1:0]  mask_pad;
	logic [6:0]       pop_sum;

	logic [EW-1:0]     ws_raw, ws_eff;
	logic [WINDOW-1:0] cell_hit, hit_ok;
	logic [NODES-1:0]  entry [WINDOW];
	logic [IW-1:0]     hit_idx;
	logic              any_hit, do_cmp, match, limit_hit, out_load;

	logic             out_valid_q;
	logic [1:0]       out_status_q;
	logic [5:0]       out_len_q;
	logic [63:0]      out_name_q, out_mask_q;
	logic [6:0]       out_float_q;

	// window chain, entry 0 is the newest state
	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		logic [NODES-1:0] newer, older;
		if (i == 0) begin : g_head
			assign newer = s_q;
		end else begin : g_body
			assign newer = entry[i-1];
		end
		if (i == WINDOW - 1) begin : g_tail
			assign older = '0;
		end else begin : g_next
			assign older = entry[i+1];
		end
		wscd_cell #(.W(NODES)) u_cell (
			.clk        (clk),
			.op         (cell_op),
			.newer_data (newer),
			.older_data (older),
			.probe      (s_q),
			.entry      (entry[i]),
			.hit        (cell_hit[i])
		);
		// only filled entries closer than the window size count
		assign hit_ok[i] = cell_hit[i] && (CW'(i) < fill_eff) && (EW'(i + 1) < ws_eff);
	end

	// search state as seen by the current item, restart clears it
	assign fill_eff   = rst_q ? '0 : fill_q;
	assign step_eff   = rst_q ? '0 : step_q;
	assign status_eff = rst_q ? wscd_pkg::STAT_SEARCH : status_q;

	// window size clamped to the supported range
	assign ws_raw = EW'(window_size_q);
	always_comb begin
		if (ws_raw < EW'(2)) begin
			ws_eff = EW'(2);
		end else if (ws_raw > EW'(WINDOW)) begin
			ws_eff = EW'(WINDOW);
		end else begin
			ws_eff = ws_raw;
		end
	end

	// nearest matching entry
	always_comb begin
		hit_idx = '0;
		for (int i = WINDOW - 1; i >= 0; i--) begin
			if (hit_ok[i]) begin
				hit_idx = IW'(i);
			end
		end
	end

	assign any_hit   = |hit_ok;
	assign do_cmp    = step_eff >= 24'(ws_eff);
	assign match     = do_cmp && any_hit;
	assign d_val     = 6'(hit_idx) + 6'd1;
	assign limit_hit = ({1'b0, step_eff} + 25'd1) >= {1'b0, step_limit_q};
	assign step_inc  = (step_eff == wscd_pkg::STEP_MAX) ? step_eff : step_eff + 24'd1;
	assign fill_inc  = (fill_eff == CW'(WINDOW)) ? fill_eff : fill_eff + CW'(1);

	// cycle accumulation over the draining chain
	assign scan_name = (entry[0] > acc_name_q) ? entry[0] : acc_name_q;
	assign scan_mask = acc_mask_q & ~(entry[0] ^ s_q);

	// floating count from the per-byte counts
	assign mask_pad = (NB * 8)'(held_mask_q);
	always_comb begin
		pop_sum = '0;
		for (int j = 0; j < NB; j++) begin
			pop_sum = pop_sum + 7'(byte_cnt_q[j]);
		end
	end

	assign out_load = (state_q == wscd_pkg::ST_DONE) && (!out_valid_q || !out_stall);

	// sequencer next state and chain operation
	always_comb begin
		state_d = state_q;
		cell_op = wscd_pkg::CELL_HOLD;
		case (state_q)
			wscd_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = wscd_pkg::ST_EVAL;
				end
			end
			wscd_pkg::ST_EVAL: begin
				if (status_eff != wscd_pkg::STAT_SEARCH) begin
					state_d = wscd_pkg::ST_DONE;
				end else if (match) begin
					state_d = wscd_pkg::ST_SCAN;
				end else begin
					cell_op = wscd_pkg::CELL_PUSH;
					state_d = wscd_pkg::ST_DONE;
				end
			end
			wscd_pkg::ST_SCAN: begin
				cell_op = wscd_pkg::CELL_DRAIN;
				if (cnt_q == 6'd1) begin
					state_d = wscd_pkg::ST_COUNT;
				end
			end
			wscd_pkg::ST_COUNT: begin
				state_d = wscd_pkg::ST_DONE;
			end
			wscd_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = wscd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wscd_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != wscd_pkg::ST_IDLE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wscd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= wscd_pkg::WINDOW_SIZE_RST;
			step_limit_q  <= wscd_pkg::STEP_LIMIT_RST;
		end else if (cfg_en) begin
			case (cfg_index)
				wscd_pkg::CFG_WINDOW_SIZE: window_size_q <= cfg_data[5:0];
				wscd_pkg::CFG_STEP_LIMIT:  step_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// search control: fill, step count and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			step_q   <= '0;
			status_q <= wscd_pkg::STAT_SEARCH;
		end else begin
			if (state_q == wscd_pkg::ST_EVAL && status_eff == wscd_pkg::STAT_SEARCH) begin
				if (match) begin
					fill_q   <= fill_eff;
					step_q   <= step_eff;
					status_q <= wscd_pkg::STAT_SEARCH;
				end else begin
					fill_q   <= fill_inc;
					step_q   <= step_inc;
					status_q <= limit_hit ? wscd_pkg::STAT_LIMIT : wscd_pkg::STAT_SEARCH;
				end
			end else if (state_q == wscd_pkg::ST_SCAN && cnt_q == 6'd1) begin
				status_q <= wscd_pkg::STAT_FOUND;
			end
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// item capture, cycle accumulation and held result
	always_ff @(posedge clk) begin
		if (state_q == wscd_pkg::ST_IDLE && in_valid) begin
			s_q   <= state_bits[NODES-1:0];
			rst_q <= restart;
		end
		if (state_q == wscd_pkg::ST_EVAL && status_eff == wscd_pkg::STAT_SEARCH && match) begin
			cnt_q      <= d_val;
			held_len_q <= d_val;
			acc_name_q <= s_q;
			acc_mask_q <= NODE_MASK;
		end
		if (state_q == wscd_pkg::ST_SCAN) begin
			cnt_q      <= cnt_q - 6'd1;
			acc_name_q <= scan_name;
			acc_mask_q <= scan_mask;
			if (cnt_q == 6'd1) begin
				held_name_q <= scan_name;
				held_mask_q <= scan_mask;
			end
		end
		if (state_q == wscd_pkg::ST_COUNT) begin
			for (int j = 0; j < NB; j++) begin
				byte_cnt_q[j] <= wscd_pkg::pop8(mask_pad[j*8 +: 8]);
			end
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= status_q;
			if (status_q == wscd_pkg::STAT_FOUND) begin
				out_len_q   <= held_len_q;
				out_name_q  <= 64'(held_name_q);
				out_mask_q  <= 64'(held_mask_q);
				out_float_q <= 7'(NODES) - pop_sum;
			end else begin
				out_len_q   <= '0;
				out_name_q  <= '0;
				out_mask_q  <= '0;
				out_float_q <= '0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign cycle_length   = out_len_q;
	assign cycle_name     = out_name_q;
	assign fixed_mask     = out_mask_q;
	assign floating_count = out_float_q;

endmodule

>>> hw/rtl/wscd_check.sv
// ----------------------------------------------------------------------------
// wscd_check: port level checks of the state cycle detector
// Watches the channels of the top level and checks result consistency
// and the one-item-at-a-time input behavior.
// ----------------------------------------------------------------------------
module wscd_check #(
	parameter int NODES = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [5:0]  cycle_length,
	input logic [63:0] cycle_name,
	input logic [63:0] fixed_mask,
	input logic [6:0]  floating_count
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
			&& $stable(cycle_name) && $stable(fixed_mask))
		else $error("result beat changed while stalled");

	// no cycle data unless a cycle was found
	a_no_cycle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != wscd_pkg::STAT_FOUND |->
			cycle_length == 6'd0 && cycle_name == 64'd0
			&& fixed_mask == 64'd0 && floating_count == 7'd0)
		else $error("cycle fields set without a found cycle");

	// found cycle is not empty and the node counts agree
	a_found_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == wscd_pkg::STAT_FOUND |->
			cycle_length != 6'd0
			&& floating_count == 7'(NODES) - 7'($countones(fixed_mask)))
		else $error("found cycle fields inconsistent");

	// one item in flight: busy right after an accepted beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while an item is in flight");

endmodule

bind windowed_state_cycle_detector_top wscd_check #(.NODES(NODES)) u_wscd_check (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.status         (status),
	.cycle_length   (cycle_length),
	.cycle_name     (cycle_name),
	.fixed_mask     (fixed_mask),
	.floating_count (floating_count)
);

>>> test/tb_windowed_state_cycle_detector_top.sv
// ----------------------------------------------------------------------------
// tb_windowed_state_cycle_detector_top: self-checking bench of the cycle detector
// Feeds network state trajectories that settle into cycles, plus noise and
// broken sequences, through the valid/stall input channel while the output
// side stalls on its own pattern. Every result beat is checked field by field
// against a trajectory tracker kept in the bench or a literal row result; register
// writes happen only while the block is drained.
// ----------------------------------------------------------------------------
module tb_windowed_state_cycle_detector_top;

	localparam int NODES      = 64;
	localparam int WINDOW     = 32;
	localparam int IDLE_LIMIT = 5000;
	localparam int ITEM_GOAL  = 1050;

	localparam logic [63:0] NODE_MASK = {64{1'b1}} >> (64 - NODES);
	localparam logic [63:0] ALL_ONES  = {64{1'b1}};

	// one result beat
	typedef struct packed {
		wscd_pkg::status_t st;
		logic [5:0]        len;
		logic [63:0]       name;
		logic [63:0]       mask;
		logic [6:0]        flt;
	} report_t;

	localparam report_t R_IDLE  = '{wscd_pkg::STAT_SEARCH, 6'd0, 64'd0, 64'd0, 7'd0};
	localparam report_t R_LIMIT = '{wscd_pkg::STAT_LIMIT, 6'd0, 64'd0, 64'd0, 7'd0};
	localparam report_t R_ZERO1 = '{wscd_pkg::STAT_FOUND, 6'd1, 64'd0, ALL_ONES, 7'd0};
	localparam report_t R_ONES1 = '{wscd_pkg::STAT_FOUND, 6'd1, ALL_ONES, ALL_ONES, 7'd0};

	// directed stimulus rows
	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_ITEM,
		ROW_CHECKED
	} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic        flag;   // restart, or register index on a write
		logic [63:0] val;    // state, or register data on a write
		report_t     lit;
	} dir_row_t;

	localparam logic [63:0] ST_A = 64'h8000_0000_0000_00F0;
	localparam logic [63:0] ST_B = 64'h0000_0000_0000_00F1;
	localparam logic [63:0] ST_C = 64'h7FFF_FFFF_FFFF_FF0F;
	localparam logic [63:0] ST_D = 64'hDEAD_BEEF_0BAD_F00D;
	localparam logic [63:0] ST_E = 64'h0123_4567_89AB_CDEF;
	localparam logic [63:0] ST_5 = 64'h5555_5555_5555_5555;
	localparam logic [63:0] ST_AA = 64'hAAAA_AAAA_AAAA_AAAA;

	dir_row_t dir_tab [34] = '{
		// smallest window: fixed points of all zeros and all ones
		'{ROW_CFG,     wscd_pkg::CFG_WINDOW_SIZE, 64'd2,    R_IDLE},
		'{ROW_CHECKED, 1'b1, 64'd0,    R_IDLE},
		'{ROW_CHECKED, 1'b0, 64'd0,    R_IDLE},
		'{ROW_CHECKED, 1'b0, 64'd0,    R_ZERO1},
		'{ROW_CHECKED, 1'b0, ALL_ONES, R_ZERO1},
		'{ROW_CHECKED, 1'b1, ALL_ONES, R_IDLE},
		'{ROW_CHECKED, 1'b0, ALL_ONES, R_IDLE},
		'{ROW_CHECKED, 1'b0, ALL_ONES, R_ONES1},
		'{ROW_CHECKED, 1'b1, ST_5,     R_IDLE},
		'{ROW_CHECKED, 1'b0, ST_AA,    R_IDLE},
		'{ROW_ITEM,    1'b0, ST_5,     R_IDLE},
		'{ROW_ITEM,    1'b0, ST_5,     R_IDLE},
		// window below range acts as two
		'{ROW_CFG,     wscd_pkg::CFG_WINDOW_SIZE, 64'd0, R_IDLE},
		'{ROW_ITEM,    1'b1, ST_E,     R_IDLE},
		'{ROW_ITEM,    1'b0, ST_E,     R_IDLE},
		'{ROW_ITEM,    1'b0, ST_E,     R_IDLE},
		// step limit zero and one stop on the first beat
		'{ROW_CFG,     wscd_pkg::CFG_STEP_LIMIT, 64'd0, R_IDLE},
		'{ROW_CHECKED, 1'b1, ALL_ONES, R_LIMIT},
		'{ROW_CHECKED, 1'b0, 64'd0,    R_LIMIT},
		'{ROW_CFG,     wscd_pkg::CFG_STEP_LIMIT, 64'd1, R_IDLE},
		'{ROW_CHECKED, 1'b1, 64'd0,    R_LIMIT},
		// limit hit while the window still fills, window above range
		'{ROW_CFG,     wscd_pkg::CFG_STEP_LIMIT, 64'd2, R_IDLE},
		'{ROW_CFG,     wscd_pkg::CFG_WINDOW_SIZE, 64'd33, R_IDLE},
		'{ROW_CHECKED, 1'b1, ST_D,     R_IDLE},
		'{ROW_CHECKED, 1'b0, ST_D,     R_LIMIT},
		// three state cycle, then held
		'{ROW_CFG,     wscd_pkg::CFG_STEP_LIMIT, 64'hFF_FFFF, R_IDLE},
		'{ROW_CFG,     wscd_pkg::CFG_WINDOW_SIZE, 64'd4, R_IDLE},
		'{ROW_ITEM,    1'b1, ST_A,     R_IDLE},
		'{ROW_ITEM,    1'b0, ST_B,     R_IDLE},
		'{ROW_ITEM,    1'b0, ST_C,     R_IDLE},
		'{ROW_ITEM,    1'b0, ST_A,     R_IDLE},
		'{ROW_ITEM,    1'b0, ST_B,     R_IDLE},
		'{ROW_ITEM,    1'b0, ST_C,     R_IDLE},
		'{ROW_CFG,     wscd_pkg::CFG_WINDOW_SIZE, 64'd63, R_IDLE}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_en = 1'b0;
	logic        cfg_index = wscd_pkg::CFG_WINDOW_SIZE;
	logic [23:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [63:0] state_bits = '0;
	logic        restart = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [5:0]  cycle_length;
	logic [63:0] cycle_name;
	logic [63:0] fixed_mask;
	logic [6:0]  floating_count;

	windowed_state_cycle_detector_top #(
		.NODES (NODES),
		.WINDOW(WINDOW)
	) DUT (.*);

	// clock
	always #2 clk = ~clk;

	// trajectory tracker state
	logic [63:0]       trail [WINDOW];
	int                trail_fill = 0;
	logic [23:0]       trail_steps = '0;
	wscd_pkg::status_t trail_status = wscd_pkg::STAT_SEARCH;
	logic [5:0]        held_len = '0;
	logic [63:0]       held_name = '0;
	logic [63:0]       held_mask = '0;
	logic [5:0]        win_cfg = wscd_pkg::WINDOW_SIZE_RST;
	logic [23:0]       lim_cfg = wscd_pkg::STEP_LIMIT_RST;

	report_t expected_reports [$];

	int items_sent   = 0;
	int reports_seen = 0;
	int found_seen   = 0;
	int limit_seen   = 0;
	int reg_writes   = 0;
	int fail_count   = 0;
	int burst_left   = 0;

	// tracks one state of the trajectory and returns the report it causes
	function automatic report_t advance_trajectory(input logic [63:0] s_in, input logic rs);
		logic [63:0] s;
		logic [63:0] nm;
		logic [63:0] mk;
		int          ws;
		int          pos;
		report_t     r;
		s = s_in & NODE_MASK;
		if (rs) begin
			trail_fill   = 0;
			trail_steps  = '0;
			trail_status = wscd_pkg::STAT_SEARCH;
			held_len     = '0;
			held_name    = '0;
			held_mask    = '0;
		end
		ws = int'(win_cfg);
		if (ws < 2) ws = 2;
		if (ws > WINDOW) ws = WINDOW;
		if (trail_status == wscd_pkg::STAT_SEARCH) begin
			pos = int'(trail_steps);
			// newest first, only filled entries
			if (pos >= ws) begin
				for (int d = 1; d < ws && d <= trail_fill; d++) begin
					if (trail_status == wscd_pkg::STAT_SEARCH && trail[d-1] == s) begin
						nm = s;
						mk = NODE_MASK;
						for (int k = 0; k < d; k++) begin
							if (trail[k] > nm) nm = trail[k];
							mk = mk & ~(trail[k] ^ s);
						end
						trail_status = wscd_pkg::STAT_FOUND;
						held_len     = 6'(d);
						held_name    = nm;
						held_mask    = mk & NODE_MASK;
					end
				end
			end
			// no repeat: shift in and count the step
			if (trail_status == wscd_pkg::STAT_SEARCH) begin
				for (int k = WINDOW - 1; k > 0; k--) trail[k] = trail[k-1];
				trail[0] = s;
				if (trail_fill < WINDOW) trail_fill++;
				if (trail_steps != wscd_pkg::STEP_MAX) trail_steps = trail_steps + 24'd1;
				if (pos + 1 >= int'(lim_cfg)) trail_status = wscd_pkg::STAT_LIMIT;
			end
		end
		r = R_IDLE;
		r.st = trail_status;
		if (trail_status == wscd_pkg::STAT_FOUND) begin
			r.len  = held_len;
			r.name = held_name;
			r.mask = held_mask;
			r.flt  = 7'(NODES - $countones(held_mask));
		end
		return r;
	endfunction

	function automatic logic [63:0] rand_state();
		return {$urandom, $urandom};
	endfunction

	function automatic bit field_ok(input string fname, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, fname, exp_v, act_v);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// one input beat, sender idles in bursts and gaps
	task automatic send_beat(input logic [63:0] s, input logic rs, input bit use_lit,
			input report_t lit);
		int      gap;
		report_t pred;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
			                                         : $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid   <= 1'b1;
		state_bits <= s;
		restart    <= rs;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pred = advance_trajectory(s, rs);
		expected_reports.push_back(use_lit ? lit : pred);
		items_sent++;
		burst_left--;
	endtask

	// drain the block, then write one register
	task automatic write_reg(input logic idx, input logic [23:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_reports.size() != 0) @(posedge clk);
		cfg_en    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_en <= 1'b0;
		if (idx == wscd_pkg::CFG_WINDOW_SIZE) win_cfg = v[5:0];
		else lim_cfg = v;
		reg_writes++;
	endtask

	function automatic logic [23:0] pick_window();
		case ($urandom_range(0, 15))
			0:       return 24'd0;
			1:       return 24'd1;
			2:       return 24'd32;
			3:       return 24'd63;
			4:       return 24'd33;
			5:       return 24'($urandom_range(9, 31));
			default: return 24'($urandom_range(2, 8));
		endcase
	endfunction

	function automatic logic [23:0] pick_limit();
		case ($urandom_range(0, 7))
			0:       return 24'd0;
			1:       return 24'd1;
			3:       return 24'($urandom_range(2, 60));
			4:       return 24'($urandom_range(2, 24'hFF_FFFF));
			default: return wscd_pkg::STEP_MAX;
		endcase
	endfunction

	// trajectory: prefix, then a cycle repeated to the end of the run
	task automatic run_trajectory;
		logic [63:0] base;
		logic [63:0] vary;
		logic [63:0] s;
		logic [63:0] cyc [40];
		int          ws_eff;
		int          p;
		int          cl;
		int          n;
		logic        first_rs;
		ws_eff = int'(win_cfg);
		if (ws_eff < 2) ws_eff = 2;
		if (ws_eff > WINDOW) ws_eff = WINDOW;
		first_rs = ($urandom_range(0, 9) != 0);
		base = rand_state();
		case ($urandom_range(0, 3))
			0:       vary = ALL_ONES;
			1:       vary = rand_state();
			2:       vary = rand_state() & rand_state() & rand_state();
			default: vary = (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
		endcase
		// a cycle as long as the window or longer is never found
		cl = ($urandom_range(0, 7) == 0) ? $urandom_range(ws_eff, ws_eff + 4)
		                                 : $urandom_range(1, ws_eff - 1);
		for (int i = 0; i < cl; i++) cyc[i] = base ^ (rand_state() & vary);
		p = $urandom_range(0, ws_eff + 2);
		n = p + ws_eff + 2 * cl + $urandom_range(0, 3);
		for (int i = 0; i < n; i++) begin
			if (i < p) s = base ^ (rand_state() & vary);
			else s = cyc[(i - p) % cl];
			if ($urandom_range(0, 39) == 0) s = rand_state();
			send_beat(s, (i == 0) ? first_rs : 1'b0, 1'b0, R_IDLE);
		end
	endtask

	// short noisy run with stray restarts
	task automatic run_noise;
		logic [63:0] pair0;
		logic [63:0] pair1;
		logic [63:0] s;
		int          n;
		pair0 = rand_state();
		pair1 = pair0 ^ (64'd1 << $urandom_range(0, 63));
		n = $urandom_range(1, 20);
		repeat (n) begin
			case ($urandom_range(0, 2))
				0:       s = pair0;
				1:       s = pair1;
				default: s = rand_state();
			endcase
			send_beat(s, $urandom_range(0, 7) == 0, 1'b0, R_IDLE);
		end
	endtask

	// result checking and receiver stall pattern
	int         stall_left = 0;
	logic [1:0] stall_mode = 2'd0;
	logic [7:0] rx_cycle = '0;

	always @(posedge clk) begin : check_reports
		report_t exp_r;
		bit      ok;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					$display("%0t: result beat with nothing expected, status %0d", $time, status);
					fail_count++;
				end else begin
					exp_r = expected_reports.pop_front();
					ok = field_ok("status", 64'(exp_r.st), 64'(status))
					   & field_ok("cycle_length", 64'(exp_r.len), 64'(cycle_length))
					   & field_ok("cycle_name", exp_r.name, cycle_name)
					   & field_ok("fixed_mask", exp_r.mask, fixed_mask)
					   & field_ok("floating_count", 64'(exp_r.flt), 64'(floating_count));
					if (!ok) fail_count++;
					if (exp_r.st == wscd_pkg::STAT_FOUND) found_seen++;
					if (exp_r.st == wscd_pkg::STAT_LIMIT) limit_seen++;
					reports_seen++;
				end
			end
			rx_cycle <= rx_cycle + 8'd1;
			if (stall_left == 0) begin
				stall_mode <= 2'($urandom_range(0, 3));
				stall_left <= $urandom_range(20, 200);
			end else begin
				stall_left <= stall_left - 1;
			end
			case (stall_mode)
				2'd0:    out_stall <= 1'b0;
				2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
				2'd2:    out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= rx_cycle[3];
			endcase
		end
	end

	// watchdog on cycles without any accepted beat
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_en) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// main sequence
	initial begin
		for (int k = 0; k < WINDOW; k++) trail[k] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		foreach (dir_tab[i]) begin
			case (dir_tab[i].kind)
				ROW_CFG:     write_reg(dir_tab[i].flag, dir_tab[i].val[23:0]);
				ROW_ITEM:    send_beat(dir_tab[i].val, dir_tab[i].flag, 1'b0, R_IDLE);
				default:     send_beat(dir_tab[i].val, dir_tab[i].flag, 1'b1, dir_tab[i].lit);
			endcase
		end

		// random phases, registers changed only between them
		while (items_sent < ITEM_GOAL) begin
			if ($urandom_range(0, 2) == 0) write_reg(wscd_pkg::CFG_WINDOW_SIZE, pick_window());
			if ($urandom_range(0, 3) == 0) write_reg(wscd_pkg::CFG_STEP_LIMIT, pick_limit());
			repeat ($urandom_range(1, 3)) begin
				if (items_sent < ITEM_GOAL) begin
					if ($urandom_range(0, 5) == 0) run_noise();
					else run_trajectory();
				end
			end
		end

		// drain and let the block settle
		in_valid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("sent %0d state beats, checked %0d results after %0d register writes",
			items_sent, reports_seen, reg_writes);
		$display("results with a cycle found: %0d, with the step limit reached: %0d",
			found_seen, limit_seen);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
